FILE: rtl/fact_pkg.sv
`timescale 1ns / 1ps

package fact_pkg;

    // fixed field and register widths
    localparam int ADDR_IN_W  = 32;
    localparam int OUT_IDX_W  = 3;
    localparam int POLICY_W   = 2;
    localparam int OFFSET_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

    // replacement policy codes (fifo and the unused code share the age search)
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU    = 2'd1;

    // register reset values
    localparam logic [POLICY_W-1:0] POLICY_RESET = POL_LRU;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd2;

    // galois lfsr, shifting right
    localparam int              LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // control part of the search token that walks the cell chain
    typedef struct packed {
        logic vld;
        logic req;
        logic hit;
        logic free;
    } t_tok_ctl;

    // update broadcast to all cells when a request commits
    typedef struct packed {
        logic inc_all;
        logic touch;
        logic write;
    } t_upd_ctl;

endpackage

FILE: rtl/fully_assoc_cache_tag_store.sv
`timescale 1ns / 1ps
// an accepted request beat launches a search token that walks the cell chain one line
// per cycle; a fill into a full store under random replacement then passes through S_MOD
// for the victim remainder; the result register loads when S_DONE commits, which waits
// while a held result is stalled; no new request is taken until the previous one commits
// reset: synchronous active low; clears line valid bits and ages, seeds the lfsr to 0xACE1,
// sets policy to lru and offset to 2; stored addresses are not cleared
module fully_assoc_cache_tag_store #(
    parameter int LINES     = 8,
    parameter int ADDR_BITS = 32,
    parameter int AGE_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [fact_pkg::ADDR_IN_W-1:0]    i_address,
    input  logic                              i_cfg_we,
    input  logic [fact_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fact_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [fact_pkg::OUT_IDX_W-1:0]    o_line_index,
    output logic                              o_replaced
);

    localparam int IDX_W = $clog2(LINES);

    // token links, entry 0 is the chain head
    fact_pkg::t_tok_ctl    w_tok      [LINES+1];
    logic [IDX_W-1:0]      w_hit_idx  [LINES+1];
    logic [IDX_W-1:0]      w_free_idx [LINES+1];
    logic [AGE_BITS-1:0]   w_best_age [LINES+1];
    logic [IDX_W-1:0]      w_best_idx [LINES+1];
    logic [ADDR_BITS-1:0]  w_addr     [LINES+1];

    logic [ADDR_BITS-1:0]  w_tag_mask;
    fact_pkg::t_upd_ctl    w_upd;
    logic [IDX_W-1:0]      w_upd_idx;

    // search starts with nothing found and age zero as the best
    assign w_hit_idx[0]  = '0;
    assign w_free_idx[0] = '0;
    assign w_best_age[0] = '0;
    assign w_best_idx[0] = '0;

    fact_ctrl #(
        .LINES      (LINES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_line_index (o_line_index),
        .o_replaced   (o_replaced),
        .o_tok        (w_tok[0]),
        .o_addr       (w_addr[0]),
        .o_tag_mask   (w_tag_mask),
        .i_tok        (w_tok[LINES]),
        .i_hit_idx    (w_hit_idx[LINES]),
        .i_free_idx   (w_free_idx[LINES]),
        .i_best_idx   (w_best_idx[LINES]),
        .o_upd        (w_upd),
        .o_upd_idx    (w_upd_idx)
    );

    // row of line cells
    for (genvar g = 0; g < LINES; g++) begin : g_cell
        fact_cell #(
            .LINES      (LINES),
            .ADDR_BITS  (ADDR_BITS),
            .AGE_BITS   (AGE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_best_age  (w_best_age[g]),
            .i_best_idx  (w_best_idx[g]),
            .i_addr      (w_addr[g]),
            .i_tag_mask  (w_tag_mask),
            .o_tok       (w_tok[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_best_age  (w_best_age[g+1]),
            .o_best_idx  (w_best_idx[g+1]),
            .o_addr      (w_addr[g+1]),
            .i_upd       (w_upd),
            .i_upd_idx   (w_upd_idx),
            .i_upd_addr  (w_addr[0])
        );
    end

endmodule

FILE: rtl/fact_cell.sv
`timescale 1ns / 1ps

module fact_cell #(
    parameter int LINES     = 8,
    parameter int ADDR_BITS = 32,
    parameter int AGE_BITS  = 16,
    parameter int CELL_IDX  = 0,
    localparam int IDX_W    = $clog2(LINES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // token from the previous cell
    input  fact_pkg::t_tok_ctl    i_tok,
    input  logic [IDX_W-1:0]      i_hit_idx,
    input  logic [IDX_W-1:0]      i_free_idx,
    input  logic [AGE_BITS-1:0]   i_best_age,
    input  logic [IDX_W-1:0]      i_best_idx,
    input  logic [ADDR_BITS-1:0]  i_addr,
    input  logic [ADDR_BITS-1:0]  i_tag_mask,
    // token to the next cell
    output fact_pkg::t_tok_ctl    o_tok,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic [AGE_BITS-1:0]   o_best_age,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [ADDR_BITS-1:0]  o_addr,
    // commit broadcast
    input  fact_pkg::t_upd_ctl    i_upd,
    input  logic [IDX_W-1:0]      i_upd_idx,
    input  logic [ADDR_BITS-1:0]  i_upd_addr
);

    localparam logic [IDX_W-1:0]    MY_IDX  = IDX_W'(CELL_IDX);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic                 r_valid;
    logic [ADDR_BITS-1:0] r_line_addr;
    logic [AGE_BITS-1:0]  r_age;

    fact_pkg::t_tok_ctl   r_tok,      n_tok;
    logic [IDX_W-1:0]     r_hit_idx,  n_hit_idx;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic [AGE_BITS-1:0]  r_best_age, n_best_age;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic [ADDR_BITS-1:0] r_addr;

    logic w_match;
    logic w_tgt;

    // tag compare on the masked address bits
    assign w_match = r_valid && (((r_line_addr ^ i_addr) & i_tag_mask) == '0);
    assign w_tgt   = (i_upd_idx == MY_IDX);

    // fold this line into the running search
    always_comb begin
        n_tok      = i_tok;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        n_best_age = i_best_age;
        n_best_idx = i_best_idx;
        if (!i_tok.hit && w_match) begin
            n_tok.hit = 1'b1;
            n_hit_idx = MY_IDX;
        end
        if (!i_tok.free && !r_valid) begin
            n_tok.free = 1'b1;
            n_free_idx = MY_IDX;
        end
        if (r_age > i_best_age) begin
            n_best_age = r_age;
            n_best_idx = MY_IDX;
        end
    end

    // token stage, control part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // token stage, payload part
    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_best_age <= n_best_age;
        r_best_idx <= n_best_idx;
        r_addr     <= i_addr;
    end

    // line valid and age
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (i_upd.write && w_tgt) begin
            r_valid <= 1'b1;
            r_age   <= '0;
        end else if (i_upd.touch && w_tgt) begin
            r_age   <= AGE_BITS'(1);
        end else if ((i_upd.inc_all || i_upd.touch) && (r_age != AGE_MAX)) begin
            r_age   <= r_age + AGE_BITS'(1);
        end
    end

    // stored line address
    always_ff @(posedge i_clk) begin
        if (i_upd.write && w_tgt) begin
            r_line_addr <= i_upd_addr;
        end
    end

    assign o_tok      = r_tok;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;
    assign o_best_age = r_best_age;
    assign o_best_idx = r_best_idx;
    assign o_addr     = r_addr;

endmodule

FILE: rtl/fact_ctrl.sv
`timescale 1ns / 1ps

module fact_ctrl #(
    parameter int LINES     = 8,
    parameter int ADDR_BITS = 32,
    localparam int IDX_W    = $clog2(LINES)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [fact_pkg::ADDR_IN_W-1:0]        i_address,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [fact_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fact_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_hit,
    output logic [fact_pkg::OUT_IDX_W-1:0]        o_line_index,
    output logic                                  o_replaced,
    // chain head
    output fact_pkg::t_tok_ctl                    o_tok,
    output logic [ADDR_BITS-1:0]                  o_addr,
    output logic [ADDR_BITS-1:0]                  o_tag_mask,
    // chain tail
    input  fact_pkg::t_tok_ctl                    i_tok,
    input  logic [IDX_W-1:0]                      i_hit_idx,
    input  logic [IDX_W-1:0]                      i_free_idx,
    input  logic [IDX_W-1:0]                      i_best_idx,
    // commit broadcast
    output fact_pkg::t_upd_ctl                    o_upd,
    output logic [IDX_W-1:0]                      o_upd_idx
);

    // reciprocal of the line count, exact for every lfsr value
    localparam int RCP_SH = fact_pkg::LFSR_W + IDX_W;
    localparam int RCP_W  = fact_pkg::LFSR_W + 2;
    localparam int PROD_W = fact_pkg::LFSR_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((1 << RCP_SH) + LINES - 1) / LINES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MOD,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic [fact_pkg::POLICY_W-1:0]         r_policy;
    logic [fact_pkg::OFFSET_W-1:0]         r_offset;
    logic [fact_pkg::LFSR_W-1:0]           r_lfsr;
    fact_pkg::t_tok_ctl                    r_launch;
    logic [ADDR_BITS-1:0]                  r_addr;
    logic                                  r_res_hit;
    logic [IDX_W-1:0]                      r_res_idx;
    logic                                  r_res_repl;
    fact_pkg::t_upd_ctl                    r_upd_pend;
    logic [fact_pkg::LFSR_W-1:0]           r_mod_val;
    logic [PROD_W-1:0]                     r_mod_prod;
    logic                                  r_out_valid;
    logic                                  r_out_hit;
    logic [fact_pkg::OUT_IDX_W-1:0]        r_out_idx;
    logic                                  r_out_repl;

    logic                                  w_accept;
    logic                                  w_commit;
    logic [fact_pkg::LFSR_W-1:0]           w_lfsr_next;
    logic [fact_pkg::LFSR_W-1:0]           w_quot;
    logic [fact_pkg::LFSR_W-1:0]           w_rem;
    logic [IDX_W+fact_pkg::OUT_IDX_W-1:0]  w_idx_ext;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // lfsr step
    assign w_lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? fact_pkg::LFSR_TAPS : '0);

    // victim remainder from the registered reciprocal product
    assign w_quot = fact_pkg::LFSR_W'(r_mod_prod >> RCP_SH);
    assign w_rem  = r_mod_val - fact_pkg::LFSR_W'(w_quot * LINES);

    assign w_idx_ext = {{fact_pkg::OUT_IDX_W{1'b0}}, r_res_idx};

    // request sequencer, config registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= fact_pkg::POLICY_RESET;
            r_offset    <= fact_pkg::OFFSET_RESET;
            r_lfsr      <= fact_pkg::LFSR_SEED;
            r_launch    <= '0;
            r_upd_pend  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= '0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    fact_pkg::CFG_POLICY: begin
                        r_policy <= i_cfg_data[fact_pkg::POLICY_W-1:0];
                    end
                    fact_pkg::CFG_OFFSET: begin
                        r_offset <= i_cfg_data[fact_pkg::OFFSET_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_launch.vld <= 1'b1;
                        r_launch.req <= i_req_type;
                        r_addr       <= i_address[ADDR_BITS-1:0];
                        r_state      <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (i_tok.vld) begin
                        r_res_hit  <= 1'b0;
                        r_res_repl <= 1'b0;
                        r_upd_pend <= '0;
                        r_state    <= S_DONE;
                        if (!i_tok.req) begin
                            // lookup
                            r_res_hit        <= i_tok.hit;
                            r_res_idx        <= i_tok.hit ? i_hit_idx : '0;
                            r_upd_pend.touch <= i_tok.hit && (r_policy == fact_pkg::POL_LRU);
                        end else if (i_tok.free) begin
                            // fill into a free line
                            r_res_idx        <= i_free_idx;
                            r_upd_pend.write <= 1'b1;
                        end else begin
                            // fill into a full store
                            r_res_repl       <= 1'b1;
                            r_upd_pend.write <= 1'b1;
                            if (r_policy == fact_pkg::POL_RANDOM) begin
                                r_lfsr     <= w_lfsr_next;
                                r_mod_val  <= w_lfsr_next;
                                r_mod_prod <= PROD_W'(w_lfsr_next) * PROD_W'(RCP_M);
                                r_state    <= S_MOD;
                            end else begin
                                r_res_idx          <= i_best_idx;
                                r_upd_pend.inc_all <= 1'b1;
                            end
                        end
                    end
                end
                S_MOD: begin
                    r_res_idx <= w_rem[IDX_W-1:0];
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // result register
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= r_res_hit;
                r_out_idx   <= w_idx_ext[fact_pkg::OUT_IDX_W-1:0];
                r_out_repl  <= r_res_repl;
            end
        end
    end

    // tag mask from the offset
    assign o_tag_mask = (int'(r_offset) >= ADDR_BITS) ? '0 :
                        ({ADDR_BITS{1'b1}} << r_offset);

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_line_index = r_out_idx;
    assign o_replaced   = r_out_repl;
    assign o_tok        = r_launch;
    assign o_addr       = r_addr;
    assign o_upd        = w_commit ? r_upd_pend : '0;
    assign o_upd_idx    = r_res_idx;

`ifndef SYNTHESIS
    // no token in the chain while the block is idle
    a_idle_no_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_tok.vld)
        else $error("token in chain while idle");

    // an accepted beat launches a token next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_launch.vld)
        else $error("accepted beat did not launch");

    // aging of all lines only with a victim write
    a_inc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_upd.inc_all |-> (o_upd.write && !o_upd.touch))
        else $error("age increment without fill");

    // an eviction is never reported as a hit
    a_repl_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_repl) |-> !r_out_hit)
        else $error("replaced result marked as hit");

    // remainder stays below the line count
    a_mod_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (w_rem < fact_pkg::LFSR_W'(LINES)))
        else $error("victim remainder out of range");
`endif

endmodule
